### design/assembly_token_scanner_core_defines.svh
// ----------------------------------------------------------------------------
// assembly token scanner assertion macros
// shared concurrent assertion forms, clocked on clk, quiet while in reset
// ----------------------------------------------------------------------------
`ifndef ASSEMBLY_TOKEN_SCANNER_CORE_DEFINES_SVH
`define ASSEMBLY_TOKEN_SCANNER_CORE_DEFINES_SVH

// same-cycle implication
`define ATS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ATS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/ats_pkg.sv
// ----------------------------------------------------------------------------
// ats_pkg
// state codes, token kinds, result record and the scanner transition table
// ----------------------------------------------------------------------------
package ats_pkg;

	typedef logic [3:0] scan_state_t;

	localparam scan_state_t S_START    = 4'd0;
	localparam scan_state_t S_ID       = 4'd1;
	localparam scan_state_t S_LABEL    = 4'd2;
	localparam scan_state_t S_COMMA    = 4'd3;
	localparam scan_state_t S_LPAREN   = 4'd4;
	localparam scan_state_t S_RPAREN   = 4'd5;
	localparam scan_state_t S_ZERO     = 4'd6;
	localparam scan_state_t S_INT      = 4'd7;
	localparam scan_state_t S_DASH     = 4'd8;
	localparam scan_state_t S_ZEROHEX  = 4'd9;
	localparam scan_state_t S_HEXINT   = 4'd10;
	localparam scan_state_t S_DOLLAR   = 4'd11;
	localparam scan_state_t S_REGISTER = 4'd12;
	localparam scan_state_t S_WSPACE   = 4'd13;
	localparam scan_state_t S_COMMENT  = 4'd14;
	localparam scan_state_t S_NONE     = 4'd15;

	typedef logic [2:0] token_kind_t;

	localparam token_kind_t K_ID       = 3'd0;
	localparam token_kind_t K_LABEL    = 3'd1;
	localparam token_kind_t K_COMMA    = 3'd2;
	localparam token_kind_t K_LPAREN   = 3'd3;
	localparam token_kind_t K_RPAREN   = 3'd4;
	localparam token_kind_t K_INT      = 3'd5;
	localparam token_kind_t K_HEXINT   = 3'd6;
	localparam token_kind_t K_REGISTER = 3'd7;

	localparam int OUT_BITS   = 16;
	localparam int FIFO_DEPTH = 4;

	typedef logic [7:0] char_t;

	// control state handed between the state registers and the step logic
	typedef struct packed {
		scan_state_t state;
		logic        discarding;
	} scan_ctl_t;

	// one result word
	typedef struct packed {
		token_kind_t           kind;
		logic [OUT_BITS-1:0]   start;
		logic [OUT_BITS-1:0]   length;
		logic                  scan_error;
		logic                  run_last;
	} result_t;

	function automatic logic is_digit(input char_t c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_alpha(input char_t c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	endfunction

	function automatic logic is_space(input char_t c);
		return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
	endfunction

	function automatic logic is_xdigit(input char_t c);
		return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
	endfunction

	// transition table, character range check is left to the caller
	function automatic scan_state_t next_state(input scan_state_t s, input char_t c);
		scan_state_t nx;
		nx = S_NONE;
		case (s)
			S_START: begin
				if (is_alpha(c))       nx = S_ID;
				else if (c == "0")     nx = S_ZERO;
				else if (is_digit(c))  nx = S_INT;
				else if (c == "-")     nx = S_DASH;
				else if (c == ";")     nx = S_COMMENT;
				else if (is_space(c))  nx = S_WSPACE;
				else if (c == "$")     nx = S_DOLLAR;
				else if (c == ",")     nx = S_COMMA;
				else if (c == "(")     nx = S_LPAREN;
				else if (c == ")")     nx = S_RPAREN;
			end
			S_ID: begin
				if (is_alpha(c) || is_digit(c)) nx = S_ID;
				else if (c == ":")              nx = S_LABEL;
			end
			S_ZERO: begin
				if (c == "x")         nx = S_ZEROHEX;
				else if (is_digit(c)) nx = S_INT;
			end
			S_ZEROHEX, S_HEXINT: begin
				if (is_xdigit(c)) nx = S_HEXINT;
			end
			S_DASH, S_INT: begin
				if (is_digit(c)) nx = S_INT;
			end
			S_COMMENT: begin
				if (c != 8'h0a) nx = S_COMMENT;
			end
			S_WSPACE: begin
				if (is_space(c)) nx = S_WSPACE;
			end
			S_DOLLAR, S_REGISTER: begin
				if (is_digit(c)) nx = S_REGISTER;
			end
			default: nx = S_NONE;
		endcase
		return nx;
	endfunction

	function automatic logic is_accepting(input scan_state_t s);
		return (s != S_START) && (s != S_DASH) && (s != S_ZEROHEX) &&
			(s != S_DOLLAR) && (s != S_NONE);
	endfunction

	// whitespace and comments produce no word
	function automatic logic is_dropped(input scan_state_t s);
		return (s == S_WSPACE) || (s == S_COMMENT);
	endfunction

	function automatic token_kind_t kind_of(input scan_state_t s);
		token_kind_t k;
		case (s)
			S_ID:          k = K_ID;
			S_LABEL:       k = K_LABEL;
			S_COMMA:       k = K_COMMA;
			S_LPAREN:      k = K_LPAREN;
			S_RPAREN:      k = K_RPAREN;
			S_ZERO, S_INT: k = K_INT;
			S_HEXINT:      k = K_HEXINT;
			default:       k = K_REGISTER;
		endcase
		return k;
	endfunction

endpackage

### design/assembly_token_scanner_core.sv
// ----------------------------------------------------------------------------
// assembly_token_scanner_core
// longest-match token scanner for assembly text, one byte per word
// ----------------------------------------------------------------------------
// The block takes one byte of text per cycle on the slave stream (tlast marks
// the final byte of a text) and produces token words on the master stream:
// kind, start position and length, or an error word after which the rest of
// the text is dropped. A byte passes an input register, then table lookup and
// bookkeeping write up to two words into a four-word output queue that feeds
// the master port. Input is taken every cycle as long as the queue has room
// for two words; a byte that closes one token and fails or ends the text
// yields two words, and those are drained at one word per cycle by the master
// port while it is ready. Whitespace and comments give no words. Positions
// count from zero per text and saturate.
`include "assembly_token_scanner_core_defines.svh"

module assembly_token_scanner_core #(
	parameter int POSITION_BITS = 16,
	parameter int CHAR_CODES    = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // text_byte
	input  logic        s_axis_tlast,   // end_of_text
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // token_start, token_length
	output logic [3:0]  m_axis_tuser,   // token_kind, scan_error
	output logic        m_axis_tlast    // run_last
);
	import ats_pkg::*;

	logic                     valid_s1;
	char_t                    byte_s1;
	logic                     last_s1;
	logic                     advance;
	logic                     room;

	scan_ctl_t                ctl_q;
	logic [POSITION_BITS-1:0] start_q;
	logic [POSITION_BITS-1:0] length_q;
	logic [POSITION_BITS-1:0] pos_q;

	scan_ctl_t                nxt_ctl;
	logic [POSITION_BITS-1:0] nxt_start;
	logic [POSITION_BITS-1:0] nxt_length;
	logic [POSITION_BITS-1:0] nxt_pos;
	result_t                  res0;
	result_t                  res1;
	logic [1:0]               res_count;
	logic [1:0]               push_count;
	result_t                  out_word;

	assign advance       = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || room;
	assign push_count    = advance ? res_count : 2'd0;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q    <= '{state: S_START, discarding: 1'b0};
			start_q  <= '0;
			length_q <= '0;
			pos_q    <= '0;
		end else if (advance) begin
			ctl_q    <= nxt_ctl;
			start_q  <= nxt_start;
			length_q <= nxt_length;
			pos_q    <= nxt_pos;
		end
	end

	ats_step #(
		.POSITION_BITS (POSITION_BITS),
		.CHAR_CODES    (CHAR_CODES)
	) u_step (
		.text_byte    (byte_s1),
		.end_of_text  (last_s1),
		.ctl          (ctl_q),
		.cur_start    (start_q),
		.cur_length   (length_q),
		.position     (pos_q),
		.nxt_ctl      (nxt_ctl),
		.nxt_start    (nxt_start),
		.nxt_length   (nxt_length),
		.nxt_position (nxt_pos),
		.res0         (res0),
		.res1         (res1),
		.res_count    (res_count)
	);

	ats_out_fifo u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_count (push_count),
		.push0      (res0),
		.push1      (res1),
		.room       (room),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_word   (out_word)
	);

	// output word packing
	assign m_axis_tdata = {out_word.length, out_word.start};
	assign m_axis_tuser = {out_word.scan_error, out_word.kind};
	assign m_axis_tlast = out_word.run_last;

	`ATS_ASSERT_NOW(a_discard_quiet, advance && ctl_q.discarding && !last_s1, res_count == 2'd0, "word produced while discarding")
	`ATS_ASSERT_NOW(a_pair_order, res_count == 2'd2, !res0.scan_error && res1.run_last && !res0.run_last, "bad order in a word pair")
	`ATS_ASSERT_NEXT(a_text_restart, advance && last_s1, ctl_q.state == S_START && !ctl_q.discarding && pos_q == '0, "state not cleared after end of text")

endmodule

### design/ats_step.sv
// ----------------------------------------------------------------------------
// ats_step
// one byte of scanner work: next state, token bookkeeping and up to two results
// ----------------------------------------------------------------------------
module ats_step #(
	parameter int POSITION_BITS = 16,
	parameter int CHAR_CODES    = 256
) (
	input  ats_pkg::char_t                text_byte,
	input  logic                          end_of_text,
	input  ats_pkg::scan_ctl_t            ctl,
	input  logic [POSITION_BITS-1:0]      cur_start,
	input  logic [POSITION_BITS-1:0]      cur_length,
	input  logic [POSITION_BITS-1:0]      position,
	output ats_pkg::scan_ctl_t            nxt_ctl,
	output logic [POSITION_BITS-1:0]      nxt_start,
	output logic [POSITION_BITS-1:0]      nxt_length,
	output logic [POSITION_BITS-1:0]      nxt_position,
	output ats_pkg::result_t              res0,
	output ats_pkg::result_t              res1,
	output logic [1:0]                    res_count
);
	import ats_pkg::*;

	localparam logic [POSITION_BITS-1:0] POS_MAX   = '1;
	localparam logic [POSITION_BITS-1:0] CLAMP_LIM = POSITION_BITS'(17'h0ffff);

	function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
		return (v == POS_MAX) ? v : v + 1'b1;
	endfunction

	function automatic logic [OUT_BITS-1:0] clamp_out(input logic [POSITION_BITS-1:0] v);
		return (v > CLAMP_LIM) ? {OUT_BITS{1'b1}} : OUT_BITS'(v);
	endfunction

	logic                     in_range;
	scan_state_t              nx0;
	scan_state_t              nx;
	scan_state_t              s_eff;
	logic [POSITION_BITS-1:0] base_start;
	logic [POSITION_BITS-1:0] base_length;
	result_t                  r_a;
	result_t                  r_b;
	logic                     va;
	logic                     vb;

	// bytes at or above the character range fail everywhere
	assign in_range = {1'b0, text_byte} < 9'(CHAR_CODES);

	// token scan for one byte
	always_comb begin
		nxt_ctl     = ctl;
		nxt_start   = cur_start;
		nxt_length  = cur_length;
		nx0         = S_NONE;
		nx          = S_NONE;
		s_eff       = ctl.state;
		base_start  = cur_start;
		base_length = cur_length;
		r_a         = '0;
		r_b         = '0;
		va          = 1'b0;
		vb          = 1'b0;
		if (!ctl.discarding) begin
			nx0 = in_range ? next_state(ctl.state, text_byte) : S_NONE;
			nx  = nx0;
			// byte ends an accepted token, then restarts from start
			if ((nx0 == S_NONE) && is_accepting(ctl.state)) begin
				if (!is_dropped(ctl.state)) begin
					va         = 1'b1;
					r_a.kind   = kind_of(ctl.state);
					r_a.start  = clamp_out(cur_start);
					r_a.length = clamp_out(cur_length);
				end
				s_eff = S_START;
				nx    = in_range ? next_state(S_START, text_byte) : S_NONE;
			end
			if (nx == S_NONE) begin
				// no way forward: error word and drop the rest of the text
				vb             = 1'b1;
				r_b.kind       = K_ID;
				r_b.scan_error = 1'b1;
				if (s_eff == S_START) begin
					r_b.start  = clamp_out(position);
					r_b.length = OUT_BITS'(1);
				end else begin
					r_b.start  = clamp_out(cur_start);
					r_b.length = clamp_out(sat_inc(cur_length));
				end
				nxt_ctl.discarding = 1'b1;
			end else begin
				if (s_eff == S_START) begin
					base_start  = position;
					base_length = '0;
				end
				nxt_start     = base_start;
				nxt_length    = sat_inc(base_length);
				nxt_ctl.state = nx;
				// end of text flushes the open token
				if (end_of_text) begin
					if (is_accepting(nx)) begin
						if (!is_dropped(nx)) begin
							vb         = 1'b1;
							r_b.kind   = kind_of(nx);
							r_b.start  = clamp_out(base_start);
							r_b.length = clamp_out(sat_inc(base_length));
						end
					end else begin
						vb             = 1'b1;
						r_b.kind       = K_ID;
						r_b.scan_error = 1'b1;
						r_b.start      = clamp_out(base_start);
						r_b.length     = clamp_out(sat_inc(base_length));
					end
				end
			end
		end
		// end of text returns everything to reset values
		if (end_of_text) begin
			nxt_ctl.state      = S_START;
			nxt_ctl.discarding = 1'b0;
			nxt_start          = '0;
			nxt_length         = '0;
			nxt_position       = '0;
		end else begin
			nxt_position = sat_inc(position);
		end
	end

	// pack the results in order and mark the last one
	always_comb begin
		if (va) begin
			res0      = r_a;
			res1      = r_b;
			res_count = vb ? 2'd2 : 2'd1;
		end else begin
			res0      = r_b;
			res1      = r_b;
			res_count = vb ? 2'd1 : 2'd0;
		end
		res0.run_last = (res_count == 2'd1);
		res1.run_last = (res_count == 2'd2);
	end

endmodule

### design/ats_out_fifo.sv
// ----------------------------------------------------------------------------
// ats_out_fifo
// four-word result queue, takes up to two words per cycle while it has room for two, gives one when read
// ----------------------------------------------------------------------------
`include "assembly_token_scanner_core_defines.svh"

module ats_out_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       push_count,
	input  ats_pkg::result_t push0,
	input  ats_pkg::result_t push1,
	output logic             room,
	output logic             out_valid,
	input  logic             out_ready,
	output ats_pkg::result_t out_word
);
	import ats_pkg::*;

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	result_t         slot_q [FIFO_DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   count_q;
	logic            pop;
	logic [PW-1:0]   wr_next;

	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign out_word  = slot_q[rd_q];
	// room for two words regardless of the read side
	assign room      = count_q <= CW'(FIFO_DEPTH - 2);
	assign wr_next   = wr_q + 1'b1;

	// word storage
	always_ff @(posedge clk) begin
		if (push_count != 2'd0) slot_q[wr_q] <= push0;
		if (push_count == 2'd2) slot_q[wr_next] <= push1;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PW'(push_count);
			rd_q    <= rd_q + PW'(pop);
			count_q <= count_q + CW'(push_count) - CW'(pop);
		end
	end

	`ATS_ASSERT_NOW(a_fifo_bound, 1'b1, count_q <= CW'(FIFO_DEPTH), "result queue overfilled")
	`ATS_ASSERT_NOW(a_fifo_push_room, push_count != 2'd0, room, "push into a full result queue")

endmodule

### tb/sv/assembly_token_scanner_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// assembly_token_scanner_core_tb
// self-checking bench for the streaming assembly token scanner
// ----------------------------------------------------------------------------
// Text bytes go in on the slave stream with random gaps and tokens come back
// on the master stream with random stalls. A scanner written here tracks the
// lexer state per accepted byte and queues the token words it should emit;
// each returned word is checked against the oldest queued one. A short
// scripted text set comes first, then random texts made mostly of well-formed
// tokens with some noise, broken bytes and dangling partial tokens.
module assembly_token_scanner_core_tb;

	import ats_pkg::*;

	localparam int        CYCLE_LIMIT  = 1_000_000;
	localparam int        RANDOM_ITEMS = 700;
	localparam int        HOLD_CYCLES  = 300;
	localparam logic [15:0] POS_TOP    = 16'hffff;
	localparam char_t     NEWLINE      = 8'h0a;

	typedef struct {
		char_t   ch;
		logic    last;
		logic    typed;
		result_t word;
	} script_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;   // text_byte
	logic        s_axis_tlast = 1'b0;    // end_of_text
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;           // token_start, token_length
	logic [3:0]  m_axis_tuser;           // token_kind, scan_error
	logic        m_axis_tlast;           // run_last

	// scanner state mirrored on the bench side
	scan_state_t lex_state = S_START;
	logic [15:0] tok_start = '0;
	logic [15:0] tok_len = '0;
	logic [15:0] text_pos = '0;
	logic        dropping_rest = 1'b0;

	result_t expected_words[$];
	char_t   text_buf[$];
	int      mismatch_count = 0;
	int      fed_items = 0;
	int      cycle_count = 0;
	int      hold_requests = 0;
	int      holds_granted = 0;
	int      hold_left = 0;
	int      rx_stall_left = 0;
	int      rx_calm_left = 0;
	logic    tx_calm = 1'b0;

	// scripted texts: bad byte at start, one of every token kind but a plain id,
	// dangling dash, dollar cut off by a comma, id closed by a failing last byte
	script_row_t script [25] = '{
		'{8'h00, 1'b0, 1'b1, '{K_ID, 16'd0, 16'd1, 1'b1, 1'b1}},
		'{8'hff, 1'b1, 1'b0, '0},
		'{"L",   1'b0, 1'b0, '0},
		'{"1",   1'b0, 1'b0, '0},
		'{":",   1'b0, 1'b0, '0},
		'{" ",   1'b0, 1'b0, '0},
		'{"$",   1'b0, 1'b0, '0},
		'{"3",   1'b0, 1'b0, '0},
		'{",",   1'b0, 1'b0, '0},
		'{"-",   1'b0, 1'b0, '0},
		'{"7",   1'b0, 1'b0, '0},
		'{"(",   1'b0, 1'b0, '0},
		'{"0",   1'b0, 1'b0, '0},
		'{"x",   1'b0, 1'b0, '0},
		'{"f",   1'b0, 1'b0, '0},
		'{")",   1'b0, 1'b0, '0},
		'{";",   1'b0, 1'b0, '0},
		'{NEWLINE, 1'b0, 1'b0, '0},
		'{"0",   1'b1, 1'b0, '0},
		'{"-",   1'b1, 1'b1, '{K_ID, 16'd0, 16'd1, 1'b1, 1'b1}},
		'{"$",   1'b0, 1'b0, '0},
		'{",",   1'b0, 1'b1, '{K_ID, 16'd0, 16'd2, 1'b1, 1'b1}},
		'{"z",   1'b1, 1'b0, '0},
		'{"a",   1'b0, 1'b0, '0},
		'{8'h80, 1'b1, 1'b0, '0}
	};

	assembly_token_scanner_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always #5 clk = ~clk;

	// character classes
	function automatic logic lex_digit(input char_t c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic lex_letter(input char_t c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic lex_blank(input char_t c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic lex_hex(input char_t c);
		return lex_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	// one dfa step, S_NONE when the byte cannot extend the token
	function automatic scan_state_t lex_next(input scan_state_t s, input char_t c);
		case (s)
			S_START: begin
				if (lex_letter(c)) return S_ID;
				if (c == "0") return S_ZERO;
				if (lex_digit(c)) return S_INT;
				if (c == "-") return S_DASH;
				if (c == ";") return S_COMMENT;
				if (lex_blank(c)) return S_WSPACE;
				if (c == "$") return S_DOLLAR;
				if (c == ",") return S_COMMA;
				if (c == "(") return S_LPAREN;
				if (c == ")") return S_RPAREN;
				return S_NONE;
			end
			S_ID: begin
				if (lex_letter(c) || lex_digit(c)) return S_ID;
				return (c == ":") ? S_LABEL : S_NONE;
			end
			S_ZERO: begin
				if (c == "x") return S_ZEROHEX;
				return lex_digit(c) ? S_INT : S_NONE;
			end
			S_ZEROHEX, S_HEXINT: return lex_hex(c) ? S_HEXINT : S_NONE;
			S_DASH, S_INT: return lex_digit(c) ? S_INT : S_NONE;
			S_COMMENT: return (c != NEWLINE) ? S_COMMENT : S_NONE;
			S_WSPACE: return lex_blank(c) ? S_WSPACE : S_NONE;
			S_DOLLAR, S_REGISTER: return lex_digit(c) ? S_REGISTER : S_NONE;
			default: return S_NONE;
		endcase
	endfunction

	function automatic logic lex_complete(input scan_state_t s);
		return !(s inside {S_START, S_DASH, S_ZEROHEX, S_DOLLAR, S_NONE});
	endfunction

	function automatic token_kind_t lex_kind(input scan_state_t s);
		case (s)
			S_ID: return K_ID;
			S_LABEL: return K_LABEL;
			S_COMMA: return K_COMMA;
			S_LPAREN: return K_LPAREN;
			S_RPAREN: return K_RPAREN;
			S_ZERO, S_INT: return K_INT;
			S_HEXINT: return K_HEXINT;
			default: return K_REGISTER;
		endcase
	endfunction

	function automatic logic [15:0] sat_up(input logic [15:0] v);
		return (v == POS_TOP) ? v : v + 16'd1;
	endfunction

	function automatic result_t make_word(input token_kind_t k, input logic [15:0] st,
			input logic [15:0] ln, input logic err);
		result_t w;
		w.kind = k;
		w.start = st;
		w.length = ln;
		w.scan_error = err;
		w.run_last = 1'b0;
		return w;
	endfunction

	// token words caused by one byte, state advanced as a side effect
	function automatic void lex_byte(input char_t c, input logic last, output result_t found[$]);
		scan_state_t s;
		scan_state_t nx;
		found.delete();
		s = lex_state;
		if (!dropping_rest) begin
			nx = lex_next(s, c);
			// byte closes the current token and restarts from the top
			if (nx == S_NONE && lex_complete(s)) begin
				if (s != S_WSPACE && s != S_COMMENT)
					found = {found, make_word(lex_kind(s), tok_start, tok_len, 1'b0)};
				s = S_START;
				nx = lex_next(S_START, c);
			end
			if (nx == S_NONE) begin
				// error words carry kind id, rest of the text is dropped
				if (s == S_START)
					found = {found, make_word(K_ID, text_pos, 16'd1, 1'b1)};
				else
					found = {found, make_word(K_ID, tok_start, sat_up(tok_len), 1'b1)};
				dropping_rest = 1'b1;
			end else begin
				if (s == S_START) begin
					tok_start = text_pos;
					tok_len = '0;
				end
				tok_len = sat_up(tok_len);
				lex_state = nx;
				if (last) begin
					if (!lex_complete(nx))
						found = {found, make_word(K_ID, tok_start, tok_len, 1'b1)};
					else if (nx != S_WSPACE && nx != S_COMMENT)
						found = {found, make_word(lex_kind(nx), tok_start, tok_len, 1'b0)};
				end
			end
		end
		// end of text brings everything back to the reset values
		if (last) begin
			lex_state = S_START;
			tok_start = '0;
			tok_len = '0;
			text_pos = '0;
			dropping_rest = 1'b0;
		end else begin
			text_pos = sat_up(text_pos);
		end
		if (found.size() > 0)
			found[found.size() - 1].run_last = 1'b1;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 2);
		if (r < 95) return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	function automatic char_t pick_letter();
		int r;
		r = $urandom_range(0, 51);
		return (r < 26) ? char_t'(8'h61 + r) : char_t'(8'h41 + r - 26);
	endfunction

	function automatic char_t pick_digit();
		return char_t'(8'h30 + $urandom_range(0, 9));
	endfunction

	function automatic char_t pick_hex();
		int r;
		r = $urandom_range(0, 21);
		if (r < 10) return char_t'(8'h30 + r);
		if (r < 16) return char_t'(8'h61 + r - 10);
		return char_t'(8'h41 + r - 16);
	endfunction

	function automatic char_t pick_blank();
		int r;
		r = $urandom_range(0, 5);
		return (r == 5) ? char_t'(" ") : char_t'(9 + r);
	endfunction

	// append one byte to the text being built
	function automatic void add_char(input char_t c);
		text_buf = {text_buf, c};
	endfunction

	// append one well-formed token with random content
	function automatic void add_token();
		char_t b;
		case ($urandom_range(0, 11))
			0, 1: begin
				add_char(pick_letter());
				repeat ($urandom_range(0, 5))
					add_char($urandom_range(0, 1) ? pick_letter() : pick_digit());
				if ($urandom_range(0, 2) == 0)
					add_char(":");
			end
			2: add_char(",");
			3: add_char("(");
			4: add_char(")");
			5: begin
				add_char(char_t'(8'h31 + $urandom_range(0, 8)));
				repeat ($urandom_range(0, 4)) add_char(pick_digit());
			end
			6: begin
				add_char("0");
				repeat ($urandom_range(0, 2)) add_char(pick_digit());
			end
			7: begin
				add_char("-");
				repeat ($urandom_range(1, 4)) add_char(pick_digit());
			end
			8: begin
				add_char("0");
				add_char("x");
				repeat ($urandom_range(1, 4)) add_char(pick_hex());
			end
			9: begin
				add_char("$");
				repeat ($urandom_range(1, 2)) add_char(pick_digit());
			end
			10: repeat ($urandom_range(1, 3)) add_char(pick_blank());
			default: begin
				// comment body may hold any byte but a newline
				add_char(";");
				repeat ($urandom_range(0, 6)) begin
					b = char_t'($urandom_range(0, 255));
					add_char((b == NEWLINE) ? char_t'(8'h0b) : b);
				end
				if ($urandom_range(0, 4) != 0)
					add_char(NEWLINE);
			end
		endcase
	endfunction

	// random text: well-formed most of the time, else noise or broken
	function automatic void build_text();
		int r;
		text_buf.delete();
		r = $urandom_range(0, 19);
		if (r < 2) begin
			repeat ($urandom_range(1, 10)) add_char(char_t'($urandom_range(0, 255)));
			return;
		end
		repeat ($urandom_range(1, 10)) begin
			add_token();
			if ($urandom_range(0, 1)) add_char(" ");
		end
		if (r < 5) begin
			text_buf.insert($urandom_range(0, text_buf.size() - 1),
				char_t'($urandom_range(0, 255)));
		end else if (r == 5) begin
			// dangling partial token at the end of the text
			case ($urandom_range(0, 2))
				0: add_char("-");
				1: begin
					add_char("0");
					add_char("x");
				end
				default: add_char("$");
			endcase
		end
	endfunction

	// offer one byte, wait for the handshake, then queue what it should cause
	task automatic send_byte(input char_t c, input logic last, input logic typed,
			input result_t typed_word);
		result_t found[$];
		if (!tx_calm && $urandom_range(0, 9) < 4) begin
			s_axis_tvalid <= 1'b0;
			repeat (pick_gap()) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (!dropping_rest) fed_items++;
		lex_byte(c, last, found);
		if (typed)
			expected_words = {expected_words, typed_word};
		else
			foreach (found[i]) expected_words = {expected_words, found[i]};
	endtask

	// receiver: long hold on request, random stalls, calm stretches
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left--;
		end else if (holds_granted != hold_requests) begin
			holds_granted++;
			hold_left = HOLD_CYCLES - 1;
			m_axis_tready <= 1'b0;
		end else if (rx_stall_left > 0) begin
			m_axis_tready <= 1'b0;
			rx_stall_left--;
		end else begin
			m_axis_tready <= 1'b1;
			if (rx_calm_left > 0)
				rx_calm_left--;
			else if ($urandom_range(0, 9) == 0)
				rx_calm_left = $urandom_range(20, 80);
			else if ($urandom_range(0, 2) == 0)
				rx_stall_left = pick_gap();
		end
	end

	// compare every accepted word with the oldest expected one
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_words.size() == 0) begin
				$error("unexpected word: kind %0d start %0d length %0d error %0d",
					m_axis_tuser[2:0], m_axis_tdata[15:0], m_axis_tdata[31:16],
					m_axis_tuser[3]);
				mismatch_count++;
			end else begin
				want = expected_words.pop_front();
				if (m_axis_tuser[2:0] !== want.kind) begin
					$error("token_kind: expected %0d, got %0d", want.kind, m_axis_tuser[2:0]);
					mismatch_count++;
				end
				if (m_axis_tdata[15:0] !== want.start) begin
					$error("token_start: expected %0d, got %0d", want.start,
						m_axis_tdata[15:0]);
					mismatch_count++;
				end
				if (m_axis_tdata[31:16] !== want.length) begin
					$error("token_length: expected %0d, got %0d", want.length,
						m_axis_tdata[31:16]);
					mismatch_count++;
				end
				if (m_axis_tuser[3] !== want.scan_error) begin
					$error("scan_error: expected %0d, got %0d", want.scan_error,
						m_axis_tuser[3]);
					mismatch_count++;
				end
				if (m_axis_tlast !== want.run_last) begin
					$error("run_last: expected %0d, got %0d", want.run_last, m_axis_tlast);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("assembly_token_scanner_core_tb: errors");
			$finish;
		end
	end

	// stimulus
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// scripted texts
		foreach (script[i])
			send_byte(script[i].ch, script[i].last, script[i].typed, script[i].word);

		// random texts, one long receiver hold partway through
		fed_items = 0;
		while (fed_items < RANDOM_ITEMS) begin
			build_text();
			tx_calm = ($urandom_range(0, 3) == 0);
			foreach (text_buf[i]) begin
				send_byte(text_buf[i], i == text_buf.size() - 1, 1'b0, '0);
				if (hold_requests == 0 && fed_items >= RANDOM_ITEMS / 2)
					hold_requests++;
			end
		end
		s_axis_tvalid <= 1'b0;

		// drain, then give late words a chance to show up
		while (expected_words.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("assembly_token_scanner_core_tb: clean");
		else
			$display("assembly_token_scanner_core_tb: errors");
		$finish;
	end

endmodule
